### hw/rtl/mrwr_pkg.sv
package mrwr_pkg;

  localparam int NUM_BITS = 32;
  localparam int FIELD_W = 32;
  localparam int CNT_W = $clog2(NUM_BITS);

  typedef logic [NUM_BITS-1:0] val_t;
  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [CNT_W-1:0] cnt_t;

endpackage

### hw/rtl/miller_rabin_witness_round_core.sv
// Every modular multiplication runs on the shared shift-add unit. A round needs at most
// 2*NUM_BITS-1 multiplications (candidate 0xFFFFFFFF at 32 bits); trivial candidates need none.
// One item is processed at a time; the next beat is taken once the result has moved to the
// output register.
// Synchronous active-low reset returns the sequencer to idle and drops out_valid.
module miller_rabin_witness_round_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mrwr_pkg::field_t in_candidate,
  input  mrwr_pkg::field_t in_witness,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_probable_prime,
  output logic             out_witness_invalid
);
  import mrwr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_RED,
    S_STRIP,
    S_POW,
    S_POWMUL,
    S_POWSQ,
    S_CHECK,
    S_SQ,
    S_SQCHK,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  val_t   n_r, n_nxt;
  val_t   w_r, w_nxt;
  val_t   e_r, e_nxt;
  cnt_t   r_r, r_nxt;
  val_t   acc_r, acc_nxt;
  val_t   base_r, base_nxt;
  logic   pass_r, pass_nxt;
  logic   bad_r, bad_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_pp_r, out_pp_nxt;
  logic   out_wi_r, out_wi_nxt;

  logic   mm_start;
  val_t   mm_a;
  val_t   mm_b;
  logic   mm_done;
  val_t   mm_prod;
  val_t   last;

  assign last = n_r - 1'b1;

  mrwr_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .a     (mm_a),
    .b     (mm_b),
    .n     (n_r),
    .done  (mm_done),
    .prod  (mm_prod)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    w_nxt         = w_r;
    e_nxt         = e_r;
    r_nxt         = r_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    pass_nxt      = pass_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_pp_nxt    = out_pp_r;
    out_wi_nxt    = out_wi_r;
    mm_start      = 1'b0;
    mm_a          = acc_r;
    mm_b          = base_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt     = val_t'(in_candidate);
          w_nxt     = val_t'(in_witness);
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        pass_nxt = 1'b0;
        bad_nxt  = 1'b0;
        if (n_r < val_t'(2)) begin
          state_nxt = S_DONE;
        end else if (n_r == val_t'(2) || n_r == val_t'(3)) begin
          pass_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else if (!n_r[0]) begin
          state_nxt = S_DONE;
        end else begin
          bad_nxt   = (w_r < val_t'(2)) || (w_r > n_r - val_t'(2));
          e_nxt     = last;
          r_nxt     = '0;
          acc_nxt   = val_t'(1);
          mm_start  = 1'b1;
          mm_a      = val_t'(1);
          mm_b      = w_r;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        if (mm_done) begin
          base_nxt  = mm_prod;
          state_nxt = S_STRIP;
        end
      end
      S_STRIP: begin
        if (!e_r[0]) begin
          e_nxt = e_r >> 1;
          r_nxt = r_r + 1'b1;
        end else begin
          state_nxt = S_POW;
        end
      end
      S_POW: begin
        if (e_r == '0) begin
          state_nxt = S_CHECK;
        end else if (e_r[0]) begin
          mm_start  = 1'b1;
          state_nxt = S_POWMUL;
        end else begin
          mm_start  = 1'b1;
          mm_a      = base_r;
          state_nxt = S_POWSQ;
        end
      end
      S_POWMUL: begin
        if (mm_done) begin
          acc_nxt   = mm_prod;
          mm_start  = 1'b1;
          mm_a      = base_r;
          state_nxt = S_POWSQ;
        end
      end
      S_POWSQ: begin
        mm_a = base_r;
        if (mm_done) begin
          base_nxt  = mm_prod;
          e_nxt     = e_r >> 1;
          state_nxt = S_POW;
        end
      end
      S_CHECK: begin
        if (acc_r == val_t'(1) || acc_r == last) begin
          pass_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else if (r_r <= cnt_t'(1)) begin
          state_nxt = S_DONE;
        end else begin
          mm_start  = 1'b1;
          mm_b      = acc_r;
          r_nxt     = r_r - 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (mm_done) begin
          acc_nxt   = mm_prod;
          state_nxt = S_SQCHK;
        end
      end
      S_SQCHK: begin
        if (acc_r == last) begin
          pass_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else if (acc_r == val_t'(1) || r_r <= cnt_t'(1)) begin
          state_nxt = S_DONE;
        end else begin
          mm_start  = 1'b1;
          mm_b      = acc_r;
          r_nxt     = r_r - 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pp_nxt    = pass_r;
          out_wi_nxt    = bad_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r      <= n_nxt;
    w_r      <= w_nxt;
    e_r      <= e_nxt;
    r_r      <= r_nxt;
    acc_r    <= acc_nxt;
    base_r   <= base_nxt;
    pass_r   <= pass_nxt;
    bad_r    <= bad_nxt;
    out_pp_r <= out_pp_nxt;
    out_wi_r <= out_wi_nxt;
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_probable_prime  = out_pp_r;
  assign out_witness_invalid = out_wi_r;

endmodule

### hw/rtl/mrwr_mulmod.sv
module mrwr_mulmod (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  mrwr_pkg::val_t a,
  input  mrwr_pkg::val_t b,
  input  mrwr_pkg::val_t n,
  output logic           done,
  output mrwr_pkg::val_t prod
);
  import mrwr_pkg::*;

  // Shift-and-add modular product, most significant bit of b first.
  // Each bit is a doubling followed by a conditional add.
  val_t                acc_r;
  val_t                a_r;
  val_t                b_r;
  cnt_t                cnt_r;
  logic                phase_r;
  logic                run_r;
  logic                done_r;
  val_t                addend;
  logic [NUM_BITS:0]   sum;
  logic [NUM_BITS:0]   diff;
  val_t                red;

  assign addend = phase_r ? a_r : acc_r;
  assign sum    = {1'b0, acc_r} + {1'b0, addend};
  assign diff   = sum - {1'b0, n};
  assign red    = diff[NUM_BITS] ? sum[NUM_BITS-1:0] : diff[NUM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        acc_r   <= '0;
        a_r     <= a;
        b_r     <= b;
        cnt_r   <= CNT_W'(NUM_BITS - 1);
        phase_r <= 1'b0;
        run_r   <= 1'b1;
      end else if (run_r) begin
        if (!phase_r) begin
          acc_r <= red;
        end else begin
          if (b_r[NUM_BITS-1]) begin
            acc_r <= red;
          end
          b_r   <= b_r << 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end
        end
        phase_r <= !phase_r;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### hw/rtl/mrwr_checker.sv
module mrwr_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input mrwr_pkg::field_t in_candidate,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_probable_prime,
  input logic             out_witness_invalid
);
  import mrwr_pkg::*;

  // The core works on one beat at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // A new result appears only as the sequencer returns to idle.
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result presented while sequencer busy");

  // Candidates two and three are reported prime without a round.
  a_small_prime: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid &&
    (in_candidate == field_t'(2) || in_candidate == field_t'(3))
    |-> ##3 out_valid && out_probable_prime && !out_witness_invalid)
    else $error("small prime not reported on the short path");

  // A result beat holds while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_probable_prime) &&
    $stable(out_witness_invalid))
    else $error("result beat changed while stalled");

endmodule

bind miller_rabin_witness_round_core mrwr_checker u_mrwr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_candidate        (in_candidate),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_probable_prime  (out_probable_prime),
  .out_witness_invalid (out_witness_invalid)
);

### dv/testbench.sv
module testbench;
  import mrwr_pkg::*;

  typedef struct packed {
    logic probable_prime;
    logic witness_invalid;
  } verdict_t;

  class mr_scoreboard;
    verdict_t verdict_q[$];
    int errors;
    int checked;
    int primes_seen;
    int flagged_seen;

    function logic [63:0] raise_mod(logic [63:0] base, logic [63:0] e, logic [63:0] n);
      logic [63:0] acc;
      acc = 1;
      while (e != 0) begin
        if (e[0]) acc = (acc * base) % n;
        base = (base * base) % n;
        e = e >> 1;
      end
      return acc;
    endfunction

    function verdict_t judge(field_t cand_in, field_t wit_in);
      logic [63:0] n, w, d, x, last;
      int r;
      verdict_t v;
      n = val_t'(cand_in);
      w = val_t'(wit_in);
      v = '0;
      if (n < 2) return v;
      if (n == 2 || n == 3) begin
        v.probable_prime = 1'b1;
        return v;
      end
      if (!n[0]) return v;
      last = n - 1;
      v.witness_invalid = (w < 2) || (w > n - 2);
      d = last;
      r = 0;
      while (!d[0]) begin
        d = d >> 1;
        r++;
      end
      x = raise_mod(w % n, d, n);
      if (x == 1 || x == last) begin
        v.probable_prime = 1'b1;
      end else begin
        for (int i = 1; i < r; i++) begin
          x = (x * x) % n;
          if (x == last) begin
            v.probable_prime = 1'b1;
            break;
          end
          if (x == 1) break;
        end
      end
      return v;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    function void note_input(field_t cand, field_t wit);
      verdict_q.push_back(judge(cand, wit));
    endfunction

    task check_result(logic pp, logic wi);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        report($sformatf("unexpected result beat pp=%0b wi=%0b", pp, wi));
      end else begin
        want = verdict_q.pop_front();
        checked++;
        if (pp) primes_seen++;
        if (wi) flagged_seen++;
        if (pp !== want.probable_prime)
          report($sformatf("probable_prime got %0b want %0b", pp, want.probable_prime));
        if (wi !== want.witness_invalid)
          report($sformatf("witness_invalid got %0b want %0b", wi, want.witness_invalid));
      end
    endtask

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  field_t in_candidate = '0;
  field_t in_witness = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   out_probable_prime;
  logic   out_witness_invalid;

  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  mr_scoreboard sb;

  miller_rabin_witness_round_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_candidate        (in_candidate),
    .in_witness          (in_witness),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_probable_prime  (out_probable_prime),
    .out_witness_invalid (out_witness_invalid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_candidate, in_witness);
    if (rst_n && out_valid && out_ready) sb.check_result(out_probable_prime, out_witness_invalid);
  end

  task send_item(field_t cand, field_t wit);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_candidate <= cand;
    in_witness <= wit;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function field_t odd_candidate();
    field_t c;
    c = $urandom;
    if ($urandom_range(1)) c = c >> $urandom_range(28);
    c[0] = 1'b1;
    if (c < 5) c = 5;
    return c;
  endfunction

  task send_random_item();
    static field_t known_primes[10] = '{32'd5, 32'd7, 32'd13, 32'd7919, 32'd104729,
                                        32'd65537, 32'd998244353, 32'd1000000007,
                                        32'd2147483647, 32'd4294967291};
    static field_t pseudo[6] = '{32'd2047, 32'd3277, 32'd4033, 32'd4681, 32'd8321,
                                 32'd3215031751};
    field_t c, w;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      c = $urandom_range(1) ? field_t'($urandom_range(3)) : field_t'($urandom & ~32'd1);
      w = $urandom;
    end else if (pick < 35) begin
      c = known_primes[$urandom_range(9)];
      w = $urandom_range(c - 2, 2);
    end else if (pick < 75) begin
      c = odd_candidate();
      w = $urandom_range(c - 2, 2);
    end else if (pick < 85) begin
      c = pseudo[$urandom_range(5)];
      w = $urandom_range(1) ? field_t'(2) : field_t'($urandom_range(c - 2, 2));
    end else begin
      c = odd_candidate();
      w = $urandom;
    end
    send_item(c, w);
  endtask

  initial begin
    static field_t dir_cand[25] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'hFFFFFFFE, 32'd5,
                                    32'd5, 32'd5, 32'd5, 32'd5, 32'd7, 32'd561, 32'd2047,
                                    32'd3215031751, 32'd3215031751, 32'd4294967291,
                                    32'd4294967291, 32'd4294967291, 32'd4294967291,
                                    32'hFFFFFFFF, 32'hFFFFFFFF, 32'd2147483647, 32'd65537,
                                    32'd13};
    static field_t dir_wit[25] = '{32'd0, 32'd5, 32'd0, 32'hFFFFFFFF, 32'd2, 32'd3, 32'd2,
                                   32'd3, 32'd4, 32'd0, 32'd1, 32'd5, 32'd2, 32'd2, 32'd2,
                                   32'd3, 32'd2, 32'd4294967289, 32'd4294967290,
                                   32'hFFFFFFFF, 32'd2, 32'hFFFFFFFE, 32'd7, 32'd3, 32'd13};
    static int idle_set[4] = '{0, 51, 0, 14};
    static int stall_set[4] = '{0, 0, 51, 14};
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 25; i++) send_item(dir_cand[i], dir_wit[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int i = 0; i < 29; i++) send_random_item();
      drain();
    end

    stall_pct = 0;
    repeat (20) @(posedge clk);
    $display("Sent %0d beats; checked %0d results, %0d probable primes, %0d flagged witnesses.",
             items_sent, sb.checked, sb.primes_seen, sb.flagged_seen);
    $display("Pacing phases covered free flow, sender gaps, receiver stalls and both.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Timeout with %0d results outstanding.", sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
